FILE: hdl/insertion_sorter_top_defines.svh
// Assertion macros for the insertion sorter.
// Included by insertion_sorter_top; expects clk and arst_n in scope.
`ifndef INSERTION_SORTER_TOP_DEFINES_SVH
`define INSERTION_SORTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define ISORT_ASSERT_IMPL(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define ISORT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ISORT_ASSERT_IMPL(label, prop, msg)
`define ISORT_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: hdl/isort_pkg.sv
// Shared constants and controller/datapath interface types for the insertion sorter.
// No dependencies.
`timescale 1ns / 1ps

package isort_pkg;

	localparam int MAX_ITEMS = 32;
	localparam int IDX_W     = $clog2(MAX_ITEMS);
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

	typedef struct packed {
		logic load;
		logic rd_prev;
		logic shift;
		logic place;
		logic emit;
		logic clr;
	} isort_cmd_t;

	typedef struct packed {
		logic full;
		logic pos_zero;
		logic greater;
		logic last_q;
		logic emit_last;
	} isort_stat_t;

endpackage

FILE: hdl/isort_ctrl.sv
// Controller state machine of the insertion sorter.
// Depends on isort_pkg; drives isort_datapath through command and status structs.
`timescale 1ns / 1ps

module isort_ctrl import isort_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  isort_stat_t stat,
	output isort_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_CMP,
		ST_PLACE,
		ST_EMIT,
		ST_DRAIN
	} state_t;

	state_t state_q;
	logic   busy_q;

	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CHECK;
						busy_q  <= 1'b1;
					end
				end
				ST_CHECK: begin
					if (stat.full) begin
						if (stat.last_q) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_IDLE;
							busy_q  <= 1'b0;
						end
					end else if (stat.pos_zero) begin
						state_q <= ST_PLACE;
					end else begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (stat.greater) begin
						state_q <= ST_CHECK;
					end else begin
						state_q <= ST_PLACE;
					end
				end
				ST_PLACE: begin
					if (stat.last_q) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end
				end
				ST_EMIT: begin
					if (stat.emit_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		cmd         = '0;
		cmd.load    = (state_q == ST_IDLE) && start;
		cmd.rd_prev = (state_q == ST_CHECK) && !stat.full && !stat.pos_zero;
		cmd.shift   = (state_q == ST_CMP) && stat.greater;
		cmd.place   = (state_q == ST_PLACE);
		cmd.emit    = (state_q == ST_EMIT);
		cmd.clr     = (state_q == ST_DRAIN);
	end

endmodule

FILE: hdl/isort_datapath.sv
// Datapath of the insertion sorter: element memory, insert position, count and output stage.
// Depends on isort_pkg; commanded by isort_ctrl.
`timescale 1ns / 1ps

module isort_datapath import isort_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  isort_cmd_t         cmd,
	output isort_stat_t        stat,
	input  logic signed [31:0] value,
	input  logic               last,
	output logic               out_valid,
	output logic signed [31:0] sorted_value,
	output logic               last_res
);

	logic signed [31:0] mem_q [MAX_ITEMS];
	logic signed [31:0] rd_data_q;
	logic signed [31:0] value_q;
	logic               last_q;
	logic [IDX_W-1:0]   pos_q;
	logic [IDX_W-1:0]   out_idx_q;
	logic [CNT_W-1:0]   count_q;
	logic               emit_s1;
	logic               emit_last_s1;
	logic [IDX_W-1:0]   rd_addr;
	logic               rd_en;
	logic               wr_en;
	logic signed [31:0] wr_data;
	logic               emit_last;

	assign rd_en     = cmd.rd_prev || cmd.emit;
	assign rd_addr   = cmd.emit ? out_idx_q : (pos_q - IDX_W'(1));
	assign wr_en     = cmd.shift || cmd.place;
	assign wr_data   = cmd.shift ? rd_data_q : value_q;
	assign emit_last = ({1'b0, out_idx_q} + CNT_W'(1)) == count_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[pos_q] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= value;
			last_q  <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			pos_q        <= '0;
			out_idx_q    <= '0;
			emit_s1      <= 1'b0;
			emit_last_s1 <= 1'b0;
		end else begin
			emit_s1 <= cmd.emit;
			if (cmd.emit) begin
				emit_last_s1 <= emit_last;
				out_idx_q    <= out_idx_q + IDX_W'(1);
			end
			if (cmd.load) begin
				pos_q <= count_q[IDX_W-1:0];
			end else if (cmd.shift) begin
				pos_q <= pos_q - IDX_W'(1);
			end
			if (cmd.place) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.clr) begin
				count_q   <= '0;
				out_idx_q <= '0;
			end
		end
	end

	assign stat.full      = (count_q == CNT_W'(MAX_ITEMS));
	assign stat.pos_zero  = (pos_q == '0);
	assign stat.greater   = (rd_data_q > value_q);
	assign stat.last_q    = last_q;
	assign stat.emit_last = emit_last;

	assign out_valid    = emit_s1;
	assign sorted_value = rd_data_q;
	assign last_res     = emit_last_s1;

endmodule

FILE: hdl/insertion_sorter_top.sv
// Insertion sorter: an item is taken when start is high and busy is low.
// Inserting a value is a read-compare-shift walk down the stored set in the
// element memory, which has one read port and one write port.
// On a last item, all stored values follow one per cycle, read in ST_EMIT and shown from the read register.
// The receiver cannot stall: out_valid marks each result for one cycle.
// Asynchronous active-low reset empties the set; memory contents are not cleared.
`timescale 1ns / 1ps
`include "insertion_sorter_top_defines.svh"

module insertion_sorter_top import isort_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] value,
	input  logic               last,
	output logic               out_valid,
	output logic signed [31:0] sorted_value,
	output logic               last_res
);

	isort_cmd_t  cmd;
	isort_stat_t stat;

	isort_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	isort_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.value        (value),
		.last         (last),
		.out_valid    (out_valid),
		.sorted_value (sorted_value),
		.last_res     (last_res)
	);

	`ISORT_ASSERT_IMPL(a_result_while_busy, !out_valid || busy, "result strobe while idle")
	`ISORT_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy, "busy not raised after accept")
	`ISORT_ASSERT_NEXT(a_last_ends_burst, out_valid && last_res, !out_valid, "result after final")
	`ISORT_ASSERT_IMPL(a_no_write_when_full, !(stat.full && cmd.place), "store written when full")

endmodule
